### hdl/tsam_pkg.sv
`default_nettype none
package tsam_pkg;

	// Field widths.
	localparam int SAMPLE_W = 12;
	localparam int LIMIT_W  = 12;
	localparam int POS_W    = 12;

	// Burst handling.
	localparam int SAMPLES_PER_BURST = 8;
	localparam int IDX_W             = $clog2(SAMPLES_PER_BURST);
	localparam int CNT_W             = $clog2(SAMPLES_PER_BURST + 1);
	localparam int SUM_W             = SAMPLE_W + IDX_W;
	localparam int MIN_VALID         = 3;

	// Window and mapping constants.
	localparam int VALID_LOW  = 100;
	localparam int VALID_HIGH = 3900;
	localparam int RAW_LOW    = 100;
	localparam int RAW_SPAN   = 1800;

	// Serial arithmetic sizes.
	localparam int MUL_STEPS = LIMIT_W;
	localparam int DIV_W     = SAMPLE_W + LIMIT_W;
	localparam int DIV_STEPS = DIV_W;
	localparam int REM_W     = 12;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam int MAP_W     = 14;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 12;
	localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SWAP_AXES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_Y    = 3'd4;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [POS_W-1:0]    pos_t;

endpackage
`default_nettype wire

### hdl/tsam_in_if.sv
`default_nettype none
interface tsam_in_if import tsam_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_x;
	sample_t sample_y;

	modport source (output valid, output sample_x, output sample_y, input ready);
	modport sink (input valid, input sample_x, input sample_y, output ready);
endinterface
`default_nettype wire

### hdl/tsam_out_if.sv
`default_nettype none
interface tsam_out_if import tsam_pkg::*; ();
	logic valid;
	logic ready;
	logic touched;
	pos_t pos_x;
	pos_t pos_y;

	modport source (output valid, output touched, output pos_x, output pos_y, input ready);
	modport sink (input valid, input touched, input pos_x, input pos_y, output ready);
endinterface
`default_nettype wire

### hdl/touch_sample_average_and_map.sv
// Touch sample averaging and coordinate mapping.
// The samples channel carries one word per converter reading pair (sample_x,
// sample_y); a word is taken when valid and ready are both high. Words come in
// bursts of eight. A pair counts when both readings lie strictly between 100
// and 3900; counted pairs are summed. Words of a burst can be taken back to
// back. After the eighth word the block stops taking words and works out the
// result on one shared bit-serial datapath: per axis a 24-step restoring
// division for the average, a 12-step shift-add multiply by the axis limit and
// a 24-step division by 1800. The result is then loaded in the put state; with
// fewer than three counted pairs the check state goes straight there. The
// result is held in an output register: the next burst is taken while it
// waits, and only the hand-off of the following result waits on the receiver.
// The cfg port writes x_limit, y_limit, swap_axes, flip_x and flip_y by index;
// writes with other indexes are dropped. Configuration is to be written only
// while the block is idle; the block itself does not enforce this. Reset
// clears the sums, the burst position, the sequencer and the output valid, and
// restores the register defaults 319, 239, 0, 0, 0.
`default_nettype none
module touch_sample_average_and_map import tsam_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	tsam_in_if.sink                   samples,
	tsam_out_if.source                results,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam logic [2:0] ST_ACC = 3'd0;
	localparam logic [2:0] ST_CHK = 3'd1;
	localparam logic [2:0] ST_DIV = 3'd2;
	localparam logic [2:0] ST_MUL = 3'd3;
	localparam logic [2:0] ST_PUT = 3'd4;

	// Configuration registers.
	logic [LIMIT_W-1:0] x_limit_q, y_limit_q;
	logic               swap_axes_q, flip_x_q, flip_y_q;

	// Burst accumulation.
	logic [SUM_W-1:0] sum_x_q, sum_y_q;
	logic [CNT_W-1:0] valid_count_q;
	logic [IDX_W-1:0] burst_index_q;

	// Sequencer and serial datapath.
	logic [2:0]          state_q;
	logic                axis_q;       // 0 while working on x, 1 on y
	logic                div_scale_q;  // 1 when the divider runs the divide by 1800
	logic [STEP_W-1:0]   step_q;
	logic [DIV_W-1:0]    quo_q;
	logic [REM_W-1:0]    rem_q;
	logic [REM_W-1:0]    divisor_q;
	logic [SAMPLE_W-1:0] mcand_q;
	logic [LIMIT_W-1:0]  mplier_q;
	logic [DIV_W-1:0]    acc_q;
	logic [MAP_W-1:0]    map_x_q, map_y_q;
	logic                touched_q;

	// Output register.
	logic out_valid_q;
	logic out_touched_q;
	pos_t out_pos_x_q, out_pos_y_q;

	logic accept, pair_ok, last_word, out_free;
	logic [REM_W:0] shifted, diff;
	logic           qbit;
	logic [REM_W-1:0] rem_next;
	logic [DIV_W-1:0] quo_next;
	logic [MAP_W-1:0] sel_x, sel_y;

	// Flip against the limit when asked, then clamp to 0..limit.
	function automatic pos_t place_axis(input logic [MAP_W-1:0] m,
		input logic [LIMIT_W-1:0] limit, input logic flip);
		logic signed [MAP_W+1:0] v;
		logic [MAP_W+1:0]        lim_ext;
		pos_t                    r;
		lim_ext = {{(MAP_W+2-LIMIT_W){1'b0}}, limit};
		if (flip) begin
			v = $signed(lim_ext) - $signed({2'b00, m});
		end else begin
			v = $signed({2'b00, m});
		end
		if (v < 0) begin
			r = '0;
		end else if (v > $signed(lim_ext)) begin
			r = limit;
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

	assign samples.ready   = (state_q == ST_ACC);
	assign accept          = samples.valid && samples.ready;
	assign pair_ok         = (samples.sample_x > SAMPLE_W'(VALID_LOW))
			&& (samples.sample_x < SAMPLE_W'(VALID_HIGH))
			&& (samples.sample_y > SAMPLE_W'(VALID_LOW))
			&& (samples.sample_y < SAMPLE_W'(VALID_HIGH));
	assign last_word       = (burst_index_q == IDX_W'(SAMPLES_PER_BURST - 1));
	assign out_free        = !out_valid_q || results.ready;

	// One restoring division step: bring in the next dividend bit and try to
	// subtract the divisor from the partial remainder.
	assign shifted  = {rem_q, quo_q[DIV_W-1]};
	assign diff     = shifted - {1'b0, divisor_q};
	assign qbit     = !diff[REM_W];
	assign rem_next = qbit ? diff[REM_W-1:0] : shifted[REM_W-1:0];
	assign quo_next = {quo_q[DIV_W-2:0], qbit};

	// Swapping happens before mirroring and clamping.
	assign sel_x = swap_axes_q ? map_y_q : map_x_q;
	assign sel_y = swap_axes_q ? map_x_q : map_y_q;

	assign results.valid   = out_valid_q;
	assign results.touched = out_touched_q;
	assign results.pos_x   = out_pos_x_q;
	assign results.pos_y   = out_pos_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_limit_q   <= LIMIT_W'(319);
			y_limit_q   <= LIMIT_W'(239);
			swap_axes_q <= 1'b0;
			flip_x_q    <= 1'b0;
			flip_y_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_LIMIT:   x_limit_q   <= cfg_data[LIMIT_W-1:0];
				REG_Y_LIMIT:   y_limit_q   <= cfg_data[LIMIT_W-1:0];
				REG_SWAP_AXES: swap_axes_q <= cfg_data[0];
				REG_FLIP_X:    flip_x_q    <= cfg_data[0];
				REG_FLIP_Y:    flip_y_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_ACC;
			sum_x_q       <= '0;
			sum_y_q       <= '0;
			valid_count_q <= '0;
			burst_index_q <= '0;
			axis_q        <= 1'b0;
			div_scale_q   <= 1'b0;
			step_q        <= '0;
			touched_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_ACC: begin
					if (accept) begin
						if (pair_ok) begin
							sum_x_q       <= sum_x_q + SUM_W'(samples.sample_x);
							sum_y_q       <= sum_y_q + SUM_W'(samples.sample_y);
							valid_count_q <= valid_count_q + 1'b1;
						end
						burst_index_q <= burst_index_q + 1'b1;
						if (last_word) begin
							state_q <= ST_CHK;
						end
					end
				end
				ST_CHK: begin
					if (valid_count_q < CNT_W'(MIN_VALID)) begin
						touched_q <= 1'b0;
						state_q   <= ST_PUT;
					end else begin
						// Start the x average: sum_x / valid_count.
						touched_q   <= 1'b1;
						axis_q      <= 1'b0;
						div_scale_q <= 1'b0;
						quo_q       <= DIV_W'(sum_x_q);
						rem_q       <= '0;
						divisor_q   <= REM_W'(valid_count_q);
						step_q      <= '0;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					quo_q  <= quo_next;
					rem_q  <= rem_next;
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						step_q <= '0;
						if (!div_scale_q) begin
							// Average done; multiply (avg - 100) by the limit.
							mcand_q  <= quo_next[SAMPLE_W-1:0] - SAMPLE_W'(RAW_LOW);
							mplier_q <= axis_q ? y_limit_q : x_limit_q;
							acc_q    <= '0;
							state_q  <= ST_MUL;
						end else if (!axis_q) begin
							// x mapped; start the y average.
							map_x_q     <= quo_next[MAP_W-1:0];
							axis_q      <= 1'b1;
							div_scale_q <= 1'b0;
							quo_q       <= DIV_W'(sum_y_q);
							rem_q       <= '0;
							divisor_q   <= REM_W'(valid_count_q);
						end else begin
							map_y_q <= quo_next[MAP_W-1:0];
							state_q <= ST_PUT;
						end
					end
				end
				ST_MUL: begin
					// Multiplier bits enter most significant first.
					acc_q    <= {acc_q[DIV_W-2:0], 1'b0}
							+ (mplier_q[LIMIT_W-1] ? DIV_W'(mcand_q) : '0);
					mplier_q <= {mplier_q[LIMIT_W-2:0], 1'b0};
					step_q   <= step_q + 1'b1;
					if (step_q == STEP_W'(MUL_STEPS - 1)) begin
						step_q      <= '0;
						quo_q       <= {acc_q[DIV_W-2:0], 1'b0}
								+ (mplier_q[LIMIT_W-1] ? DIV_W'(mcand_q) : '0);
						rem_q       <= '0;
						divisor_q   <= REM_W'(RAW_SPAN);
						div_scale_q <= 1'b1;
						state_q     <= ST_DIV;
					end
				end
				ST_PUT: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_touched_q <= touched_q;
						if (touched_q) begin
							out_pos_x_q <= place_axis(sel_x, x_limit_q, flip_x_q);
							out_pos_y_q <= place_axis(sel_y, y_limit_q, flip_y_q);
						end else begin
							out_pos_x_q <= '0;
							out_pos_y_q <= '0;
						end
						sum_x_q       <= '0;
						sum_y_q       <= '0;
						valid_count_q <= '0;
						burst_index_q <= '0;
						state_q       <= ST_ACC;
					end
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

endmodule
`default_nettype wire
